@@ design/ajsc_pkg.sv @@
// ----------------------------------------------------------------------------
// ajsc_pkg
// Shared types and constants of the adaptive job size controller.
// ----------------------------------------------------------------------------
package ajsc_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_INITIAL_WEIGHT = 3'd0;
    localparam logic [2:0] CFG_MIN_JOB_TIME   = 3'd1;
    localparam logic [2:0] CFG_MAX_JOB_TIME   = 3'd2;
    localparam logic [2:0] CFG_EXEC_PREP_RAT  = 3'd3;
    localparam logic [2:0] CFG_BOOST_FACTOR   = 3'd4;

    // Register reset values
    localparam logic [47:0] RST_INITIAL_WEIGHT = 48'd268435456;
    localparam logic [39:0] RST_MIN_JOB_TIME   = 40'd60000000;
    localparam logic [39:0] RST_MAX_JOB_TIME   = 40'd600000000;
    localparam logic [15:0] RST_EXEC_PREP_RAT  = 16'd5120;
    localparam logic [15:0] RST_BOOST_FACTOR   = 16'd512;

    // Bytes-per-microsecond cap (1e12) with 16 fraction bits
    localparam logic [63:0] PER_US_CAP_Q16 = 64'd65536000000000000;

    localparam logic [63:0] ALL_ONES64 = {64{1'b1}};

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_M_SET,
        S_MEAN_DIV,
        S_T_SET,
        S_T_MUL,
        S_CAP_SET,
        S_CAP_MUL,
        S_P_SET,
        S_P_MUL,
        S_D_SET,
        S_P_DIV,
        S_I_SET,
        S_H_SET,
        S_H_MUL,
        S_W_SET,
        S_FIN
    } t_state;

endpackage

@@ design/adaptive_job_size_controller.sv @@
// An abandoned report goes straight to the result stage, and with empty statistics
// the arithmetic is skipped; else the sequencer runs at most a 64-step mean division,
// 16+40+40+16 multiply steps and a 64-step ideal division, with setup states between,
// on the single shift-add / shift-subtract unit that all steps share. Input stalls until
// the result word is loaded, so one report is in work at a time. Reset (synchronous,
// active low) loads register defaults, clears totals, reloads the weight; no clearing pass.
// ----------------------------------------------------------------------------
// adaptive_job_size_controller
// Keeps job statistics and, for each non-abandoned report once they hold a sample,
// recomputes the data weight per job, using one shared iterative multiply/divide unit.
// ----------------------------------------------------------------------------
module adaptive_job_size_controller
    import ajsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // report channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_abandoned,
    input  logic [39:0] i_data_bytes,
    input  logic [39:0] i_prepare_time,
    input  logic [39:0] i_download_time,
    input  logic [39:0] i_exec_time,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [47:0] o_weight_per_job,
    output logic        o_sample_used,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [47:0]  r_init_weight;
    logic [39:0]  r_min_time, r_max_time;
    logic [15:0]  r_ratio, r_boost;

    logic [31:0]  r_count, n_count;
    logic [63:0]  r_tot_prep, n_tot_prep;
    logic [63:0]  r_tot_exec, n_tot_exec;
    logic [63:0]  r_tot_data, n_tot_data;
    logic [63:0]  r_weight, n_weight;

    logic [127:0] r_acc, n_acc;
    logic [63:0]  r_opa, n_opa;
    logic [63:0]  r_opb, n_opb;
    logic [5:0]   r_cnt, n_cnt;
    logic [39:0]  r_t, n_t;
    logic [63:0]  r_cap, n_cap;
    logic [63:0]  r_ideal, n_ideal;
    logic [63:0]  r_new, n_new;
    logic         r_used, n_used;

    logic         r_out_valid, n_out_valid;
    logic [47:0]  r_out_weight, n_out_weight;
    logic         r_out_used, n_out_used;

    // Shared unit: one multiply step (MSB first) and one divide step
    logic [127:0] u_mul, u_div;
    logic [63:0]  u_rem_sh, u_rem_sub;
    logic         u_ge;

    always_comb begin
        u_mul     = {r_acc[126:0], 1'b0} + (r_opb[r_cnt] ? {64'd0, r_opa} : 128'd0);
        u_rem_sh  = r_acc[126:63];
        u_ge      = r_acc[127] || (u_rem_sh >= r_opb);
        u_rem_sub = u_rem_sh - r_opb;
        u_div     = u_ge ? {u_rem_sub, r_acc[62:0], 1'b1} : {u_rem_sh, r_acc[62:0], 1'b0};
    end

    // Report intake: net prepare time and saturating totals
    logic [39:0]  w_net;
    logic         w_use;
    logic [64:0]  w_sum_prep, w_sum_exec, w_sum_data;

    always_comb begin
        w_net      = (i_prepare_time > i_download_time) ?
                     (i_prepare_time - i_download_time) : 40'd0;
        w_use      = !i_abandoned && (i_data_bytes != 40'd0) && (w_net != 40'd0)
                     && (i_exec_time != 40'd0);
        w_sum_prep = {1'b0, r_tot_prep} + {25'd0, w_net};
        w_sum_exec = {1'b0, r_tot_exec} + {25'd0, i_exec_time};
        w_sum_data = {1'b0, r_tot_data} + {25'd0, i_data_bytes};
    end

    // Post-processing helpers
    logic [63:0]  w_t_raw, w_t_lo, w_t_cl;
    logic [63:0]  w_cap_sat, w_hi, w_lim;
    logic [127:0] w_acc_sh;

    always_comb begin
        w_t_raw   = (r_acc[127:64] != 64'd0) ? ALL_ONES64 : {8'd0, r_acc[63:8]};
        w_t_lo    = (w_t_raw < {24'd0, r_min_time}) ? {24'd0, r_min_time} : w_t_raw;
        w_t_cl    = (w_t_lo > {24'd0, r_max_time}) ? {24'd0, r_max_time} : w_t_lo;
        w_cap_sat = (r_acc[127:64] != 64'd0) ? ALL_ONES64 : r_acc[63:0];
        w_acc_sh  = {r_acc[111:0], 16'd0};
        w_hi      = (r_acc[127:72] != 56'd0) ? ALL_ONES64 : r_acc[71:8];
        w_lim     = (r_ideal > w_hi) ? w_hi : r_ideal;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_weight_per_job = r_out_weight;
    assign o_sample_used    = r_out_used;

    // Sequencer: next state and datapath loads
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_tot_prep   = r_tot_prep;
        n_tot_exec   = r_tot_exec;
        n_tot_data   = r_tot_data;
        n_weight     = r_weight;
        n_acc        = r_acc;
        n_opa        = r_opa;
        n_opb        = r_opb;
        n_cnt        = r_cnt;
        n_t          = r_t;
        n_cap        = r_cap;
        n_ideal      = r_ideal;
        n_new        = r_new;
        n_used       = r_used;
        n_out_valid  = r_out_valid;
        n_out_weight = r_out_weight;
        n_out_used   = r_out_used;

        // drop the result word once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_used = w_use;
                    n_new  = r_weight;
                    if (w_use) begin
                        n_count    = (r_count == 32'hFFFF_FFFF) ? r_count : r_count + 32'd1;
                        n_tot_prep = w_sum_prep[64] ? ALL_ONES64 : w_sum_prep[63:0];
                        n_tot_exec = w_sum_exec[64] ? ALL_ONES64 : w_sum_exec[63:0];
                        n_tot_data = w_sum_data[64] ? ALL_ONES64 : w_sum_data[63:0];
                    end
                    n_state = i_abandoned ? S_FIN : S_M_SET;
                end
            end
            S_M_SET: begin
                if (r_count == 32'd0) begin
                    n_state = S_FIN;
                end else begin
                    n_acc   = {64'd0, r_tot_prep};
                    n_opb   = {32'd0, r_count};
                    n_cnt   = 6'd63;
                    n_state = S_MEAN_DIV;
                end
            end
            S_MEAN_DIV: begin
                n_acc = u_div;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = S_T_SET;
                end
            end
            S_T_SET: begin
                n_opa   = r_acc[63:0];
                n_opb   = {48'd0, r_ratio};
                n_acc   = 128'd0;
                n_cnt   = 6'd15;
                n_state = S_T_MUL;
            end
            S_T_MUL: begin
                n_acc = u_mul;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = S_CAP_SET;
                end
            end
            S_CAP_SET: begin
                n_t     = w_t_cl[39:0];
                n_opa   = PER_US_CAP_Q16;
                n_opb   = {24'd0, w_t_cl[39:0]};
                n_acc   = 128'd0;
                n_cnt   = 6'd39;
                n_state = S_CAP_MUL;
            end
            S_CAP_MUL: begin
                n_acc = u_mul;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = S_P_SET;
                end
            end
            S_P_SET: begin
                n_cap = w_cap_sat;
                if (r_tot_exec == 64'd0) begin
                    n_ideal = w_cap_sat;
                    n_state = S_H_SET;
                end else begin
                    n_opa   = r_tot_data;
                    n_opb   = {24'd0, r_t};
                    n_acc   = 128'd0;
                    n_cnt   = 6'd39;
                    n_state = S_P_MUL;
                end
            end
            S_P_MUL: begin
                n_acc = u_mul;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = S_D_SET;
                end
            end
            S_D_SET: begin
                // quotient saturates: the cap then bounds the ideal
                if (w_acc_sh[127:64] >= r_tot_exec) begin
                    n_ideal = r_cap;
                    n_state = S_H_SET;
                end else begin
                    n_acc   = w_acc_sh;
                    n_opb   = r_tot_exec;
                    n_cnt   = 6'd63;
                    n_state = S_P_DIV;
                end
            end
            S_P_DIV: begin
                n_acc = u_div;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = S_I_SET;
                end
            end
            S_I_SET: begin
                n_ideal = (r_acc[63:0] > r_cap) ? r_cap : r_acc[63:0];
                n_state = S_H_SET;
            end
            S_H_SET: begin
                n_opa   = r_weight;
                n_opb   = {48'd0, r_boost};
                n_acc   = 128'd0;
                n_cnt   = 6'd15;
                n_state = S_H_MUL;
            end
            S_H_MUL: begin
                n_acc = u_mul;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = S_W_SET;
                end
            end
            S_W_SET: begin
                n_new   = (w_lim < r_weight) ? r_weight : w_lim;
                n_state = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_weight     = r_new;
                    n_out_valid  = 1'b1;
                    n_out_weight = r_new[63:16];
                    n_out_used   = r_used;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // initial weight write also reloads the running weight
        if (i_cfg_valid && (i_cfg_index == CFG_INITIAL_WEIGHT)) begin
            n_weight = {i_cfg_data, 16'd0};
        end
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_count       <= 32'd0;
            r_tot_prep    <= 64'd0;
            r_tot_exec    <= 64'd0;
            r_tot_data    <= 64'd0;
            r_weight      <= {RST_INITIAL_WEIGHT, 16'd0};
            r_init_weight <= RST_INITIAL_WEIGHT;
            r_min_time    <= RST_MIN_JOB_TIME;
            r_max_time    <= RST_MAX_JOB_TIME;
            r_ratio       <= RST_EXEC_PREP_RAT;
            r_boost       <= RST_BOOST_FACTOR;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_tot_prep  <= n_tot_prep;
            r_tot_exec  <= n_tot_exec;
            r_tot_data  <= n_tot_data;
            r_weight    <= n_weight;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_INITIAL_WEIGHT: r_init_weight <= i_cfg_data;
                    CFG_MIN_JOB_TIME:   r_min_time    <= i_cfg_data[39:0];
                    CFG_MAX_JOB_TIME:   r_max_time    <= i_cfg_data[39:0];
                    CFG_EXEC_PREP_RAT:  r_ratio       <= i_cfg_data[15:0];
                    CFG_BOOST_FACTOR:   r_boost       <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_acc        <= n_acc;
        r_opa        <= n_opa;
        r_opb        <= n_opb;
        r_cnt        <= n_cnt;
        r_t          <= n_t;
        r_cap        <= n_cap;
        r_ideal      <= n_ideal;
        r_new        <= n_new;
        r_used       <= n_used;
        r_out_weight <= n_out_weight;
        r_out_used   <= n_out_used;
    end

    // Assertions
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("report accepted but sequencer stayed idle");

    a_weight_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_new >= r_weight))
        else $error("weight per job would shrink");

    a_used_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_used) |-> (r_count != 32'd0))
        else $error("sample reported used with empty statistics");

    a_t_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CAP_MUL) |-> (r_t <= r_max_time))
        else $error("ideal execute time above max bound");

    a_init_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && (i_cfg_index == CFG_INITIAL_WEIGHT))
        |=> (r_weight[63:16] == r_init_weight))
        else $error("initial weight write did not reload weight");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the adaptive job size controller: a queue-fed
// driver offers job reports, a predictor keeps its own statistics and weight,
// and a monitor compares every result word with the oldest prediction.
// ----------------------------------------------------------------------------
module tb
    import ajsc_pkg::*;
();

    typedef struct packed {
        logic        abandoned;
        logic [39:0] data_bytes;
        logic [39:0] prepare_time;
        logic [39:0] download_time;
        logic [39:0] exec_time;
    } t_report;

    typedef struct packed {
        logic [47:0] weight;
        logic        used;
    } t_weight_word;

    localparam logic [39:0] MAX40 = {40{1'b1}};
    localparam logic [47:0] MAX48 = {48{1'b1}};
    localparam int          HOLD_CYCLES = 600;
    localparam int          DRAIN_CYCLES = 320;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    logic        abandoned = 1'b0;
    logic [39:0] data_bytes = '0;
    logic [39:0] prepare_time = '0;
    logic [39:0] download_time = '0;
    logic [39:0] exec_time = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b1;
    logic [47:0] o_weight_per_job;
    logic        o_sample_used;
    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;

    // Predictor configuration and state
    logic [47:0] p_init_weight;
    logic [39:0] p_min_time;
    logic [39:0] p_max_time;
    logic [15:0] p_ratio;
    logic [15:0] p_boost;
    logic [31:0] n_samples;
    logic [63:0] sum_prepare;
    logic [63:0] sum_exec;
    logic [63:0] sum_data;
    logic [63:0] weight_q16;

    t_report      pending_reports[$];
    t_weight_word expected_words[$];
    t_report      offered;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           holds_asked = 0;
    int           holds_served = 0;
    int           hold_left = 0;
    int           fail_count = 0;

    adaptive_job_size_controller i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_abandoned     (abandoned),
        .i_data_bytes    (data_bytes),
        .i_prepare_time  (prepare_time),
        .i_download_time (download_time),
        .i_exec_time     (exec_time),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_weight_per_job(o_weight_per_job),
        .o_sample_used   (o_sample_used),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("Verification failed");
        $finish;
    end

    // Work out the new weight from the running totals
    function automatic void recompute_weight();
        logic [127:0] prod;
        logic [63:0]  mean;
        logic [63:0]  t;
        logic [63:0]  cap;
        logic [63:0]  ideal;
        logic [63:0]  ceiling;
        mean = sum_prepare / {32'd0, n_samples};
        prod = {112'd0, p_ratio} * {64'd0, mean};
        t = (prod[127:64] != 0) ? ALL_ONES64 : prod[63:0];
        if (t != ALL_ONES64) t = t >> 8;
        if (t < {24'd0, p_min_time}) t = {24'd0, p_min_time};
        if (t > {24'd0, p_max_time}) t = {24'd0, p_max_time};
        prod = {64'd0, t} * {64'd0, PER_US_CAP_Q16};
        cap = (prod[127:64] != 0) ? ALL_ONES64 : prod[63:0];
        if (sum_exec == 0) begin
            ideal = cap;
        end else begin
            prod = ({64'd0, t} * {64'd0, sum_data}) << 16;
            prod = prod / {64'd0, sum_exec};
            ideal = (prod[127:64] != 0) ? ALL_ONES64 : prod[63:0];
            if (ideal > cap) ideal = cap;
        end
        prod = {64'd0, weight_q16} * {112'd0, p_boost};
        ceiling = (prod[127:72] != 0) ? ALL_ONES64 : prod[71:8];
        if (ideal > ceiling) ideal = ceiling;
        if (ideal < weight_q16) ideal = weight_q16;
        weight_q16 = ideal;
    endfunction

    // Fold one accepted report into the statistics and give its result word
    function automatic t_weight_word predict_weight(t_report r);
        t_weight_word w;
        logic [39:0]  net;
        w.used = 1'b0;
        if (!r.abandoned) begin
            net = (r.prepare_time > r.download_time) ?
                  r.prepare_time - r.download_time : '0;
            if (r.data_bytes != 0 && net != 0 && r.exec_time != 0) begin
                w.used = 1'b1;
                if (n_samples != 32'hFFFF_FFFF) n_samples = n_samples + 1;
                sum_prepare = (sum_prepare + net < sum_prepare) ?
                              ALL_ONES64 : sum_prepare + net;
                sum_exec = (sum_exec + r.exec_time < sum_exec) ?
                           ALL_ONES64 : sum_exec + r.exec_time;
                sum_data = (sum_data + r.data_bytes < sum_data) ?
                           ALL_ONES64 : sum_data + r.data_bytes;
            end
            if (n_samples != 0) recompute_weight();
        end
        w.weight = weight_q16[63:16];
        return w;
    endfunction

    // Report driver: predict on acceptance, then offer the next word or idle
    always @(posedge i_clk) begin : report_driver
        t_report nx;
        if (i_rst_n) begin
            if (in_valid && !o_in_stall)
                expected_words.push_back(predict_weight(offered));
            if (!in_valid || !o_in_stall) begin
                if (pending_reports.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    nx = pending_reports.pop_front();
                    offered = nx;
                    in_valid <= 1'b1;
                    abandoned <= nx.abandoned;
                    data_bytes <= nx.data_bytes;
                    prepare_time <= nx.prepare_time;
                    download_time <= nx.download_time;
                    exec_time <= nx.exec_time;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each accepted word, then choose the next stall
    always @(posedge i_clk) begin : result_monitor
        t_weight_word exp_w;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected: weight %0d used %0d",
                           o_weight_per_job, o_sample_used);
                    fail_count++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (o_weight_per_job !== exp_w.weight) begin
                        $error("weight_per_job: expected %0d, got %0d",
                               exp_w.weight, o_weight_per_job);
                        fail_count++;
                    end
                    if (o_sample_used !== exp_w.used) begin
                        $error("sample_used: expected %0d, got %0d",
                               exp_w.used, o_sample_used);
                        fail_count++;
                    end
                end
            end
            if (holds_asked != holds_served) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Write one register and mirror it in the predictor
    task automatic write_reg(logic [2:0] idx, logic [47:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_INITIAL_WEIGHT: begin
                p_init_weight = value;
                weight_q16 = {value, 16'd0};
            end
            CFG_MIN_JOB_TIME:  p_min_time = value[39:0];
            CFG_MAX_JOB_TIME:  p_max_time = value[39:0];
            CFG_EXEC_PREP_RAT: p_ratio = value[15:0];
            CFG_BOOST_FACTOR:  p_boost = value[15:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [47:0] iw, logic [39:0] mn, logic [39:0] mx,
                             logic [15:0] ratio, logic [15:0] boost);
        write_reg(CFG_INITIAL_WEIGHT, iw);
        write_reg(CFG_MIN_JOB_TIME, {8'd0, mn});
        write_reg(CFG_MAX_JOB_TIME, {8'd0, mx});
        write_reg(CFG_EXEC_PREP_RAT, {32'd0, ratio});
        write_reg(CFG_BOOST_FACTOR, {32'd0, boost});
    endtask

    // Hold until every report is out and answered, then let the block settle;
    // check between edges so the driver's updates are all in place
    task automatic wait_drain();
        @(negedge i_clk);
        while (pending_reports.size() != 0 || in_valid ||
               expected_words.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [39:0] rnd40();
        logic [39:0] v;
        v = 40'({$urandom, $urandom});
        case ($urandom_range(3))
            0: return v;
            1: return v >> $urandom_range(39);
            2: return v & 40'hF_FFFF;
            default: return 40'($urandom_range(1000));
        endcase
    endfunction

    function automatic t_report make_report(logic ab, logic [39:0] d,
                                            logic [39:0] p, logic [39:0] dl,
                                            logic [39:0] e);
        t_report r;
        r.abandoned = ab;
        r.data_bytes = d;
        r.prepare_time = p;
        r.download_time = dl;
        r.exec_time = e;
        return r;
    endfunction

    // Mostly usable samples, with abandoned and malformed reports mixed in
    function automatic t_report random_report();
        t_report r;
        int      kind;
        kind = $urandom_range(99);
        r = make_report(1'b0, rnd40(), rnd40(), rnd40(), rnd40());
        if (kind < 10) begin
            r.abandoned = 1'b1;
        end else if (kind < 30) begin
            case ($urandom_range(3))
                0: r.data_bytes = '0;
                1: r.exec_time = '0;
                2: r.download_time = r.prepare_time;
                default: r.download_time = r.prepare_time + rnd40();
            endcase
        end else begin
            if (r.data_bytes == 0) r.data_bytes = 40'd1;
            if (r.exec_time == 0) r.exec_time = 40'd1;
            if (r.prepare_time == 0) r.prepare_time = 40'd1;
            r.download_time = $urandom_range(1) ? '0 :
                              r.download_time % r.prepare_time;
        end
        return r;
    endfunction

    initial begin : stimulus
        p_init_weight = RST_INITIAL_WEIGHT;
        p_min_time = RST_MIN_JOB_TIME;
        p_max_time = RST_MAX_JOB_TIME;
        p_ratio = RST_EXEC_PREP_RAT;
        p_boost = RST_BOOST_FACTOR;
        n_samples = '0;
        sum_prepare = '0;
        sum_exec = '0;
        sum_data = '0;
        weight_q16 = {RST_INITIAL_WEIGHT, 16'd0};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty statistics, then edge values on reset settings
        pending_reports.push_back(make_report(1'b1, MAX40, MAX40, '0, MAX40));
        pending_reports.push_back(make_report(1'b0, '0, 40'd5, '0, 40'd5));
        pending_reports.push_back(make_report(1'b0, 40'd7, 40'd3, 40'd3, 40'd9));
        pending_reports.push_back(make_report(1'b0, 40'd1, 40'd1, '0, 40'd1));
        pending_reports.push_back(make_report(1'b0, 40'd1, 40'd4, 40'd9, 40'd1));
        pending_reports.push_back(make_report(1'b0, '0, '0, '0, '0));
        pending_reports.push_back(make_report(1'b1, 40'd1, 40'd1, '0, 40'd1));
        pending_reports.push_back(make_report(1'b0, MAX40, MAX40, '0, MAX40));
        pending_reports.push_back(make_report(1'b0, MAX40, MAX40, MAX40 - 1, 40'd1));
        pending_reports.push_back(make_report(1'b0, 40'd1, MAX40, '0, MAX40));
        pending_reports.push_back(make_report(1'b0, MAX40, 40'd1, '0, 40'd1));
        pending_reports.push_back(make_report(1'b0, MAX40, '0, MAX40, 40'd1));
        pending_reports.push_back(make_report(1'b0, 40'hAA_AAAA_AAAA,
                                              40'h55_5555_5555, 40'h1,
                                              40'hAA_AAAA_AAAA));
        wait_drain();

        // Random phases, each with its own register settings
        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 79 : 0;
            recv_idle_pct = (ph < 2) ? 79 : (ph < 4) ? 35 : 0;
            case (ph)
                0: write_all(48'd1, 40'd0, MAX40, 16'hFFFF, 16'hFFFF);
                1: write_all(MAX48, 40'd0, 40'd0, 16'd0, 16'd256);
                2: begin
                    write_all(48'd1000, 40'd500000000, 40'd100000000,
                              16'd256, 16'd300);
                    write_reg(3'd7, MAX48);
                end
                3: write_all(48'({$urandom, $urandom}) | 48'd1, rnd40(), rnd40(),
                             16'($urandom), 16'($urandom_range(65535, 256)));
                4: write_all(RST_INITIAL_WEIGHT, RST_MIN_JOB_TIME,
                             RST_MAX_JOB_TIME, RST_EXEC_PREP_RAT,
                             RST_BOOST_FACTOR);
                default: write_all(48'($urandom_range(100000, 1)), rnd40(),
                                   rnd40(), 16'($urandom),
                                   16'($urandom_range(2048, 256)));
            endcase
            for (int k = 0; k < 106; k++)
                pending_reports.push_back(random_report());
            // Hold the result side off so the block fills and stalls its input
            if (ph == 4) holds_asked++;
            wait_drain();
        end

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
